// ----- rtl/spq_pkg.sv -----
package spq_pkg;

   // Field widths of one item and one result.
   localparam int KEY_W   = 32;
   localparam int TAG_W   = 16;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 2;
   localparam int FILL_W  = 7;
   localparam int ENTRY_W = KEY_W + TAG_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_ENQ   = 2'd0,
      KIND_DEQ   = 2'd1,
      KIND_PEEK  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ENQ_RD,
      S_ENQ_CMP,
      S_DEQ_DATA,
      S_DONE
   } state_type;

   // One stored slot: key in the upper bits, tag below.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       init_pos;
      logic       rd_prev;
      logic       rd_front;
      logic       shift;
      logic       place;
      logic       take_front;
      logic       clear;
      logic       set_status;
      status_type status;
      logic       emit;
   } ctrl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      kind_type op;
      logic     full;
      logic     empty;
      logic     pos_zero;
      logic     greater;
      logic     rsp_busy;
   } dp_stat_type;

endpackage

// ----- rtl/spq_if.sv -----
// Request channel: one queue operation per beat.
interface spq_req_if;
   logic                            valid;
   logic                            ready;
   logic [spq_pkg::KIND_W-1:0]      kind;
   logic signed [spq_pkg::KEY_W-1:0] key;
   logic [spq_pkg::TAG_W-1:0]       tag;

   modport source (output valid, kind, key, tag, input ready);
   modport sink   (input valid, kind, key, tag, output ready);
endinterface

// Response channel: one result per beat.
interface spq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [spq_pkg::KEY_W-1:0] out_key;
   logic [spq_pkg::TAG_W-1:0]       out_tag;
   logic [spq_pkg::STAT_W-1:0]      status;
   logic [spq_pkg::FILL_W-1:0]      fill;

   modport source (output valid, out_key, out_tag, status, fill, input ready);
   modport sink   (input valid, out_key, out_tag, status, fill, output ready);
endinterface

// ----- rtl/spq_ram.sv -----
module spq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/spq_ctrl.sv -----
module spq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  spq_pkg::dp_stat_type  stat,
   output spq_pkg::ctrl_cmd_type cmd
);
   import spq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.op)
               KIND_ENQ:   state_in = stat.full ? S_DONE : S_ENQ_RD;
               KIND_DEQ,
               KIND_PEEK:  state_in = stat.empty ? S_DONE : S_DEQ_DATA;
               KIND_CLEAR: state_in = S_DONE;
               default:    state_in = S_DONE;
            endcase
         end
         S_ENQ_RD: begin
            state_in = stat.pos_zero ? S_DONE : S_ENQ_CMP;
         end
         S_ENQ_CMP: begin
            state_in = stat.greater ? S_ENQ_RD : S_DONE;
         end
         S_DEQ_DATA: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd        = '0;
      cmd.status = ST_OK;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_DECODE: begin
            unique case (stat.op)
               KIND_ENQ: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else begin
                     cmd.init_pos = 1'b1;
                  end
               end
               KIND_DEQ,
               KIND_PEEK: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else begin
                     cmd.rd_front = 1'b1;
                  end
               end
               KIND_CLEAR: cmd.clear = 1'b1;
               default:    cmd.clear = 1'b0;
            endcase
         end
         S_ENQ_RD: begin
            if (stat.pos_zero) begin
               cmd.place = 1'b1;
            end else begin
               cmd.rd_prev = 1'b1;
            end
         end
         S_ENQ_CMP: begin
            if (stat.greater) begin
               cmd.shift = 1'b1;
            end else begin
               cmd.place = 1'b1;
            end
         end
         S_DEQ_DATA: begin
            cmd.take_front = 1'b1;
         end
         S_DONE: begin
            cmd.emit = !stat.rsp_busy;
         end
         default: req_ready = 1'b0;
      endcase
   end

endmodule

// ----- rtl/spq_dp.sv -----
module spq_dp #(
   parameter int CAPACITY = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  spq_pkg::ctrl_cmd_type              cmd,
   output spq_pkg::dp_stat_type               stat,
   input  logic [spq_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [spq_pkg::KEY_W-1:0]   req_key,
   input  logic [spq_pkg::TAG_W-1:0]          req_tag,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [spq_pkg::KEY_W-1:0]   rsp_out_key,
   output logic [spq_pkg::TAG_W-1:0]          rsp_out_tag,
   output logic [spq_pkg::STAT_W-1:0]         rsp_status,
   output logic [spq_pkg::FILL_W-1:0]         rsp_fill
);
   import spq_pkg::*;

   localparam int AddrW  = $clog2(CAPACITY);
   localparam int CountW = $clog2(CAPACITY + 1);

   // Captured operation and working result.
   kind_type         op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [KEY_W-1:0] res_key_ff;
   logic [TAG_W-1:0] res_tag_ff;
   status_type       res_status_ff;

   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] count_in;
   logic [AddrW-1:0]  pos_ff;

   logic              rsp_valid_ff;
   logic [KEY_W-1:0]  rsp_key_ff;
   logic [TAG_W-1:0]  rsp_tag_ff;
   status_type        rsp_status_ff;
   logic [FILL_W-1:0] rsp_fill_ff;

   logic [AddrW-1:0]            front_addr;
   logic [AddrW-1:0]            rd_addr;
   logic [AddrW-1:0]            count_addr;
   entry_type                   wr_entry;
   entry_type                   rd_entry;
   logic [FILL_W+CountW-1:0]    fill_wide;

   assign count_addr = count_ff[AddrW-1:0];
   assign front_addr = count_addr - AddrW'(1);
   assign rd_addr    = cmd.rd_prev ? (pos_ff - AddrW'(1)) : front_addr;
   assign wr_entry   = cmd.shift ? rd_entry : entry_type'{key: key_ff, tag: tag_ff};

   spq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.shift | cmd.place),
      .wr_addr (pos_ff),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_prev | cmd.rd_front),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // Status toward the controller.
   assign stat.op       = op_ff;
   assign stat.full     = count_ff >= CountW'(CAPACITY);
   assign stat.empty    = count_ff == '0;
   assign stat.pos_zero = pos_ff == '0;
   assign stat.greater  = $signed(key_ff) > $signed(rd_entry.key);
   assign stat.rsp_busy = rsp_valid_ff & ~rsp_ready;

   // Entry count after the operation.
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.place) begin
         count_in = count_ff + CountW'(1);
      end else if (cmd.take_front && op_ff == KIND_DEQ) begin
         count_in = count_ff - CountW'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Operation capture, insertion position and working result.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff         <= kind_type'(req_kind);
         key_ff        <= req_key;
         tag_ff        <= req_tag;
         res_key_ff    <= '0;
         res_tag_ff    <= '0;
         res_status_ff <= ST_OK;
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status;
      end
      if (cmd.take_front) begin
         res_key_ff <= rd_entry.key;
         res_tag_ff <= rd_entry.tag;
      end
      if (cmd.init_pos) begin
         pos_ff <= count_addr;
      end else if (cmd.shift) begin
         pos_ff <= pos_ff - AddrW'(1);
      end
   end

   // Output register, loaded once the operation has finished.
   assign fill_wide = {{FILL_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_key_ff    <= res_key_ff;
         rsp_tag_ff    <= res_tag_ff;
         rsp_status_ff <= res_status_ff;
         rsp_fill_ff   <= fill_wide[FILL_W-1:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_key = rsp_key_ff;
   assign rsp_out_tag = rsp_tag_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_fill    = rsp_fill_ff;

endmodule

// ----- rtl/sorted_array_priority_queue.sv -----
// Min-priority queue held as a sorted array in a single-port-read memory.
// The req channel carries one operation per beat: enqueue (key, tag),
// dequeue, peek or clear. The rsp channel returns exactly one beat per
// operation with the front key and tag (zero unless a dequeue or peek
// succeeded), a status (ok, empty, full) and the fill after the operation.
// Among equal keys the newest entry is served first.
// Path after acceptance: the decode state, then done for clear and
// rejected items, the data state and done for dequeue and peek, or the
// read and compare states in turn for an enqueue, once for each stored
// entry with a smaller key, until the new entry is placed in its slot.
// Each of those entries is moved up one slot by a read and a write of
// the entry memory, and that loop sets the enqueue time. The block
// handles one operation at a time and takes the next one once the
// result is loaded into the output register and it is back in idle.
// If the receiver stalls, the result waits in the output register; one
// more operation may be accepted and worked on, and it waits at its end
// until the output register is free. Reset empties the queue and drops
// any pending result; no memory clearing pass is needed.
module sorted_array_priority_queue #(
   parameter int CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req,
   spq_rsp_if.source  rsp
);
   import spq_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_kind    (req.kind),
      .req_key     (req.key),
      .req_tag     (req.tag),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .rsp_out_key (rsp.out_key),
      .rsp_out_tag (rsp.out_tag),
      .rsp_status  (rsp.status),
      .rsp_fill    (rsp.fill)
   );

endmodule
